>>> rtl/xsb_pkg.sv
// Shared types, constants and coordinate wrap tables for the sprite blitter.
package xsb_pkg;

  // Display geometry
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;
  localparam int COL_W = $clog2(DISPLAY_WIDTH);
  localparam int ROW_W = $clog2(DISPLAY_HEIGHT);
  localparam int PIXELS_W = 64;

  // Operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Input word
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [3:0] row_offset;
    logic [7:0] sprite_row;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                collision;
    logic [PIXELS_W-1:0] row_pixels;
  } out_word_t;

  // Wrap tables: an 8-bit coordinate folded onto the display
  typedef logic [COL_W-1:0] col_tab_t [256];
  typedef logic [ROW_W-1:0] row_tab_t [256];

  function automatic col_tab_t build_col_tab();
    col_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = COL_W'(i % DISPLAY_WIDTH);
    end
    return t;
  endfunction

  function automatic row_tab_t build_row_tab();
    row_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ROW_W'(i % DISPLAY_HEIGHT);
    end
    return t;
  endfunction

  localparam col_tab_t COL_TAB = build_col_tab();
  localparam row_tab_t ROW_TAB = build_row_tab();

endpackage

>>> rtl/xor_sprite_blitter_collision.sv
// Top level: one-bit-per-pixel frame store with XOR sprite row drawing.

// Takes one word per cycle while item_stall is low and returns one result
// word per input word. The cycle that accepts a word does the coordinate
// wrap and the registered read of the addressed display row from the frame
// memory; stage one then does the XOR of the sprite row, the collision
// update and the write back, and loads the output register when it advances.
// The input stalls only while stage one holds a word that cannot move into a
// full, stalled output register. A word that hits the row written by the word
// just ahead of it takes that row from a forwarding register. Clear takes
// effect at once through one valid flag per display row (an invalid row reads
// as blank), so there is no clearing pass after reset or clear. The collision
// flag is cleared by a draw with row offset zero and is reported, cumulatively,
// with every result; read results carry the addressed display row, column 0
// in bit 0, and all other results carry zero pixels.
module xor_sprite_blitter_collision (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  xsb_pkg::in_word_t item,
  output logic              result_valid,
  input  logic              result_stall,
  output xsb_pkg::out_word_t result
);

  localparam int W = xsb_pkg::DISPLAY_WIDTH;
  localparam int H = xsb_pkg::DISPLAY_HEIGHT;
  localparam int CW = xsb_pkg::COL_W;
  localparam int RW = xsb_pkg::ROW_W;
  localparam int PIXELS_W = xsb_pkg::PIXELS_W;

  // Frame memory and per-row valid flags
  logic [W-1:0] frame_mem [H];
  logic [H-1:0] row_valid;
  logic         collision_seen;

  // Stage one registers
  logic              s1_valid;
  xsb_pkg::in_word_t s1_item;
  logic [RW-1:0]     s1_row;
  logic [CW-1:0]     s1_col;
  logic [W-1:0]      rd_data;
  logic              fwd_hit;
  logic [W-1:0]      fwd_data;

  logic          accept;
  logic          s1_adv;
  logic [RW-1:0] row_in;
  logic [RW-1:0] y_wrap;
  logic [7:0]    y_sum;
  logic [W-1:0]  line;
  logic [W-1:0]  toggle;
  logic [W-1:0]  line_next;
  logic [6:0]    col_sum;
  logic          collide;
  logic          collision_next;
  logic          s1_draw;
  xsb_pkg::out_word_t result_next;

  // Handshake
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;
  assign s1_draw    = (s1_item.operation == xsb_pkg::OP_DRAW);

  // Row address: wrap origin, add row offset (draws only), wrap again
  always_comb begin
    y_wrap = xsb_pkg::ROW_TAB[item.origin_y];
    y_sum  = 8'(y_wrap) + 8'(item.row_offset);
    if (item.operation == xsb_pkg::OP_DRAW) begin
      row_in = xsb_pkg::ROW_TAB[y_sum];
    end else begin
      row_in = y_wrap;
    end
  end

  // Stage one capture, registered memory read and forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= item;
      s1_row   <= row_in;
      s1_col   <= xsb_pkg::COL_TAB[item.origin_x];
      rd_data  <= frame_mem[row_in];
      fwd_hit  <= s1_adv && s1_draw && (s1_row == row_in);
      fwd_data <= line_next;
    end
  end

  // Current row contents as seen by stage one
  always_comb begin
    if (!row_valid[s1_row]) begin
      line = '0;
    end else if (fwd_hit) begin
      line = fwd_data;
    end else begin
      line = rd_data;
    end
  end

  // Toggle mask: sprite bit 7 lands on the origin column, wrapping right
  always_comb begin
    toggle = '0;
    for (int i = 0; i < 8; i++) begin
      col_sum = 7'(s1_col) + 7'(i);
      if (col_sum >= 7'(W)) begin
        col_sum = col_sum - 7'(W);
      end
      if (s1_item.sprite_row[7-i]) begin
        toggle[col_sum[CW-1:0]] = 1'b1;
      end
    end
  end

  // XOR draw and collision update
  always_comb begin
    line_next = line ^ toggle;
    collide   = |(line & toggle);
    if (s1_draw) begin
      collision_next = ((s1_item.row_offset == 4'd0) ? 1'b0 : collision_seen) | collide;
    end else begin
      collision_next = collision_seen;
    end
    result_next.collision  = collision_next;
    result_next.row_pixels = '0;
    if (s1_item.operation == xsb_pkg::OP_READ) begin
      result_next.row_pixels = PIXELS_W'(line);
    end
  end

  // Write back
  always_ff @(posedge clk) begin
    if (s1_adv && s1_draw) begin
      frame_mem[s1_row] <= line_next;
    end
  end

  // Row valid flags and collision flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      collision_seen <= 1'b0;
    end else if (s1_adv) begin
      collision_seen <= collision_next;
      if (s1_item.operation == xsb_pkg::OP_CLEAR) begin
        row_valid <= '0;
      end else if (s1_draw) begin
        row_valid[s1_row] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // Nothing in flight straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipeline not empty after reset");

  // A clear leaves every row blank
  a_clear_blanks: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_item.operation == xsb_pkg::OP_CLEAR) |=> row_valid == '0)
    else $error("rows still valid after clear");

  // Only draws touch the collision flag
  a_coll_hold: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_draw |=> collision_seen == $past(collision_seen))
    else $error("collision flag changed by a non-draw word");

  // A drawn row is marked valid
  a_draw_valid: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_draw |=> row_valid[$past(s1_row)])
    else $error("drawn row not marked valid");

  // Non-read results carry no pixels
  a_pixels_zero: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_item.operation != xsb_pkg::OP_READ) |=> result.row_pixels == '0)
    else $error("pixels on a non-read result");
`endif

endmodule
